// ===== rtl/core/sac_pkg.sv =====
// Shared types, codes and defaults for the set-associative cache simulator.
// No dependencies; used by sac_ctrl, sac_datapath and the top level.
package sac_pkg;

    // Parameter defaults
    localparam int WORD_BITS_DEF = 32;
    localparam int MAX_SETS_DEF  = 256;
    localparam int MAX_WAYS_DEF  = 8;

    // Fixed widths from the interface
    localparam int CNT_W     = 32;
    localparam int SET_OUT_W = 8;
    localparam int IB_MAX    = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLICY     = 2'd0;
    localparam logic [1:0] CFG_INDEX_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    // Replacement policies
    localparam logic POL_LRU = 1'b0;
    localparam logic POL_LFU = 1'b1;

    // Outcome codes
    localparam logic [1:0] OUT_HIT  = 2'd0;
    localparam logic [1:0] OUT_COMP = 2'd1;
    localparam logic [1:0] OUT_REPL = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic rd;
        logic scan_clr;
        logic scan_step;
        logic wr;
        logic load_out;
    } sac_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic scan_last;
    } sac_sts_t;

    // Saturating increment of a count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== rtl/core/sac_ctrl.sv =====
// Sequencing state machine for the set-associative cache simulator.
// Depends on sac_pkg for the command and status structs.
module sac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sac_pkg::sac_cmd_t cmd,
    input  sac_pkg::sac_sts_t sts
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd       = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_READ))
        else $error("accepted word did not start a set read");
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("word taken during clearing pass");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending word");
`endif

endmodule

// ===== rtl/core/sac_datapath.sv =====
// Set memory, way scan, replacement update and totals of the cache simulator.
// Depends on sac_pkg; driven by sac_ctrl commands.
module sac_datapath #(
    parameter int WORD_BITS = sac_pkg::WORD_BITS_DEF,
    parameter int MAX_SETS  = sac_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = sac_pkg::MAX_WAYS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sac_pkg::sac_cmd_t             cmd,
    output sac_pkg::sac_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [3:0]                    cfg_data,
    input  logic [WORD_BITS-1:0]          s_lookup_word,
    output logic [1:0]                    m_outcome,
    output logic [7:0]                    m_set_index,
    output logic [sac_pkg::CNT_W-1:0]     m_hit_count,
    output logic [sac_pkg::CNT_W-1:0]     m_replace_miss_count,
    output logic [sac_pkg::CNT_W-1:0]     m_compulsory_miss_count
);

    localparam int CW      = sac_pkg::CNT_W;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W  = WAY_W;
    localparam int ENTRY_W = 1 + WORD_BITS + CW + RANK_W;
    localparam int V_POS   = ENTRY_W - 1;
    localparam int T_POS   = RANK_W + CW;
    localparam int C_POS   = RANK_W;
    localparam int SHW     = $clog2(WORD_BITS + 1);
    localparam int TAB_N   = 1 << sac_pkg::SET_OUT_W;

    typedef logic [MAX_WAYS-1:0][ENTRY_W-1:0] row_t;

    // Configuration registers
    logic       policy_reg;
    logic [3:0] ib_reg;
    logic [3:0] ways_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= sac_pkg::POL_LRU;
            ib_reg     <= 4'd4;
            ways_reg   <= 4'd4;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                sac_pkg::CFG_POLICY:     policy_reg <= cfg_data[0];
                sac_pkg::CFG_INDEX_BITS: ib_reg     <= cfg_data;
                sac_pkg::CFG_WAYS:       ways_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp configuration
    logic [3:0]     ib_eff;
    logic [WAY_W:0] ways_eff;
    logic [SHW-1:0] shamt;

    always_comb begin
        ib_eff = (ib_reg > 4'(sac_pkg::IB_MAX)) ? 4'(sac_pkg::IB_MAX) : ib_reg;
        if (ways_reg == 4'd0) begin
            ways_eff = (WAY_W+1)'(1);
        end else if (32'(ways_reg) > MAX_WAYS) begin
            ways_eff = (WAY_W+1)'(MAX_WAYS);
        end else begin
            ways_eff = (WAY_W+1)'(ways_reg);
        end
        shamt = SHW'(WORD_BITS) - SHW'(ib_eff);
    end

    // Set number: top bits of the word, folded onto the set count
    logic [SET_W-1:0]     mod_tab [TAB_N];
    logic [WORD_BITS-1:0] shifted;
    logic [7:0]           set_raw;

    for (genvar g = 0; g < TAB_N; g++) begin : g_mod
        assign mod_tab[g] = SET_W'(g % MAX_SETS);
    end

    assign shifted = s_lookup_word >> shamt;
    assign set_raw = shifted[7:0];

    logic [WORD_BITS-1:0] word_reg;
    logic [SET_W-1:0]     set_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            word_reg <= s_lookup_word;
            set_reg  <= mod_tab[set_raw];
        end
    end

    // Clear counter for the pass after reset
    logic [SET_W-1:0] clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_idx_reg <= clr_idx_reg + SET_W'(1);
        end
    end

    assign sts.clr_last = (clr_idx_reg == SET_W'(MAX_SETS - 1));

    // Set memory, one row per set
    row_t             mem [MAX_SETS];
    row_t             rd_q;
    row_t             row_next;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    row_t             wr_data;

    assign wr_en   = cmd.wr || cmd.clr_step;
    assign wr_addr = cmd.wr ? set_reg : clr_idx_reg;
    assign wr_data = cmd.wr ? row_next : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_q <= mem[set_reg];
        end
    end

    // Way scan, one way per cycle
    logic [WAY_W-1:0]  way_reg;
    logic [WAY_W:0]    vcount_reg;
    logic              hit_reg;
    logic [WAY_W-1:0]  hit_slot_reg;
    logic [RANK_W-1:0] hit_rank_reg;
    logic              free_reg;
    logic [WAY_W-1:0]  free_slot_reg;
    logic              vic_reg;
    logic [WAY_W-1:0]  vic_slot_reg;
    logic [RANK_W-1:0] vic_rank_reg;
    logic [CW-1:0]     vic_cnt_reg;

    logic [ENTRY_W-1:0] cur;
    logic               cur_v;
    logic [WORD_BITS-1:0] cur_tag;
    logic [CW-1:0]      cur_cnt;
    logic [RANK_W-1:0]  cur_rank;
    logic               take_vic;

    always_comb begin
        cur      = rd_q[way_reg];
        cur_v    = cur[V_POS];
        cur_tag  = cur[T_POS +: WORD_BITS];
        cur_cnt  = cur[C_POS +: CW];
        cur_rank = cur[RANK_W-1:0];
        if (!vic_reg) begin
            take_vic = 1'b1;
        end else if (policy_reg == sac_pkg::POL_LRU) begin
            take_vic = cur_rank > vic_rank_reg;
        end else begin
            take_vic = (cur_cnt < vic_cnt_reg) ||
                       ((cur_cnt == vic_cnt_reg) && (cur_rank > vic_rank_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            way_reg    <= '0;
            vcount_reg <= '0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            vic_reg    <= 1'b0;
        end else if (cmd.scan_step) begin
            way_reg <= way_reg + WAY_W'(1);
            if (cur_v) begin
                vcount_reg <= vcount_reg + (WAY_W+1)'(1);
                if (!hit_reg && (cur_tag == word_reg)) begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= way_reg;
                    hit_rank_reg <= cur_rank;
                end
                if (take_vic) begin
                    vic_reg      <= 1'b1;
                    vic_slot_reg <= way_reg;
                    vic_rank_reg <= cur_rank;
                    vic_cnt_reg  <= cur_cnt;
                end
            end else if (!free_reg) begin
                free_reg      <= 1'b1;
                free_slot_reg <= way_reg;
            end
        end
    end

    assign sts.scan_last = (way_reg == WAY_W'(MAX_WAYS - 1));

    // Outcome and updated row
    logic              is_hit;
    logic              is_comp;
    logic [WAY_W-1:0]  tgt;
    logic [RANK_W-1:0] limit;
    logic              age_on;
    logic [1:0]        outcome;

    always_comb begin
        is_hit  = hit_reg;
        is_comp = !hit_reg && (vcount_reg < ways_eff);
        if (is_hit) begin
            outcome = sac_pkg::OUT_HIT;
            tgt     = hit_slot_reg;
            limit   = hit_rank_reg;
        end else if (is_comp) begin
            outcome = sac_pkg::OUT_COMP;
            tgt     = free_reg ? free_slot_reg : '0;
            limit   = '0;
        end else begin
            outcome = sac_pkg::OUT_REPL;
            tgt     = vic_reg ? vic_slot_reg : '0;
            limit   = vic_rank_reg;
        end
        age_on = !(is_hit && (policy_reg == sac_pkg::POL_LFU));
    end

    always_comb begin
        row_next = rd_q;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (WAY_W'(j) == tgt) begin
                if (is_hit) begin
                    row_next[j][C_POS +: CW] = sac_pkg::sat_inc(rd_q[j][C_POS +: CW]);
                    if (policy_reg == sac_pkg::POL_LRU) begin
                        row_next[j][RANK_W-1:0] = '0;
                    end
                end else begin
                    row_next[j] = {1'b1, word_reg, CW'(1), RANK_W'(0)};
                end
            end else if (rd_q[j][V_POS] && age_on &&
                         (is_comp || (rd_q[j][RANK_W-1:0] < limit))) begin
                row_next[j][RANK_W-1:0] = rd_q[j][RANK_W-1:0] + RANK_W'(1);
            end
        end
    end

    // Totals, updated on write-back
    logic [CW-1:0] hits_reg;
    logic [CW-1:0] repl_reg;
    logic [CW-1:0] comp_reg;
    logic [1:0]    outcome_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg <= '0;
            repl_reg <= '0;
            comp_reg <= '0;
        end else if (cmd.wr) begin
            unique case (outcome)
                sac_pkg::OUT_HIT:  hits_reg <= sac_pkg::sat_inc(hits_reg);
                sac_pkg::OUT_COMP: comp_reg <= sac_pkg::sat_inc(comp_reg);
                default:           repl_reg <= sac_pkg::sat_inc(repl_reg);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            outcome_reg <= outcome;
        end
    end

    // Output word registers
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_outcome               <= outcome_reg;
            m_set_index             <= 8'(set_reg);
            m_hit_count             <= hits_reg;
            m_replace_miss_count    <= repl_reg;
            m_compulsory_miss_count <= comp_reg;
        end
    end

`ifndef ASSERT_OFF
    a_comp_has_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr && is_comp) |-> free_reg)
        else $error("compulsory miss with no free way");
    a_repl_has_vic: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr && !is_hit && !is_comp) |-> vic_reg)
        else $error("replacement miss with no victim");
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr && cmd.clr_step))
        else $error("write-back during clearing pass");
`endif

endmodule

// ===== rtl/core/set_assoc_cache_lru_lfu_sim.sv =====
// Flow: an accepted word goes through the set read, a scan over the MAX_WAYS ways,
// write-back and output load, in that order; one word at a time, so no new word is
// taken until its result has been loaded into the output registers.
// Reset: synchronous active-low aresetn; afterwards a clearing pass wipes every set of
// the set memory, with no word taken until it ends.
// Top level of the set-associative cache simulator; uses sac_pkg, sac_ctrl, sac_datapath.
module set_assoc_cache_lru_lfu_sim #(
    parameter int WORD_BITS = sac_pkg::WORD_BITS_DEF,
    parameter int MAX_SETS  = sac_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = sac_pkg::MAX_WAYS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_addr,
    input  logic [3:0]                cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [WORD_BITS-1:0]      s_lookup_word,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_outcome,
    output logic [7:0]                m_set_index,
    output logic [sac_pkg::CNT_W-1:0] m_hit_count,
    output logic [sac_pkg::CNT_W-1:0] m_replace_miss_count,
    output logic [sac_pkg::CNT_W-1:0] m_compulsory_miss_count
);

    sac_pkg::sac_cmd_t cmd;
    sac_pkg::sac_sts_t sts;

    sac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sac_datapath #(
        .WORD_BITS (WORD_BITS),
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .sts                     (sts),
        .cfg_we                  (cfg_we),
        .cfg_addr                (cfg_addr),
        .cfg_data                (cfg_data),
        .s_lookup_word           (s_lookup_word),
        .m_outcome               (m_outcome),
        .m_set_index             (m_set_index),
        .m_hit_count             (m_hit_count),
        .m_replace_miss_count    (m_replace_miss_count),
        .m_compulsory_miss_count (m_compulsory_miss_count)
    );

endmodule
